// ===== rtl/tcp_window_congestion_controller_core_assert.svh =====
// Assertion macros shared by the congestion controller RTL
`ifndef TCP_WINDOW_CONGESTION_CONTROLLER_CORE_ASSERT_SVH
`define TCP_WINDOW_CONGESTION_CONTROLLER_CORE_ASSERT_SVH

// Condition that must hold at every clock edge out of reset
`define TWCC_ASSERT_ALWAYS(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// Condition in one cycle that forces another in the next cycle
`define TWCC_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/twcc_pkg.sv =====
// Shared types and constants of the congestion window controller
package twcc_pkg;

	localparam int SEQ_W   = 32;
	localparam int CWND_W  = 11;
	localparam int DUP_W   = 16;
	localparam int KIND_W  = 2;
	localparam int CFG_IDX_W = 2;
	localparam int OUT_W   = 120;
	localparam int QDEPTH  = 2;

	// window saturation point and reset threshold
	localparam logic [CWND_W-1:0] CWND_MAX     = 11'd1024;
	localparam logic [CWND_W-1:0] SSTHRESH_RST = 11'd20;

	// input kind codes
	localparam logic [KIND_W-1:0] KIND_START   = 2'd0;
	localparam logic [KIND_W-1:0] KIND_ACK     = 2'd1;
	localparam logic [KIND_W-1:0] KIND_TIMEOUT = 2'd2;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_FIRST_SEQ = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_LAST_SEQ  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_SSTHRESH  = 2'd2;

	// event class decided by the front end
	typedef enum logic [1:0] {
		EV_START,
		EV_ACK,
		EV_TIMEOUT,
		EV_NONE
	} ev_t;

	// one queued event
	typedef struct packed {
		ev_t              ev;
		logic [SEQ_W-1:0] ack;
	} ev_item_t;

	// queue to back end handshake
	typedef struct packed {
		logic     valid;
		ev_item_t item;
	} q_out_t;

endpackage

// ===== rtl/twcc_front.sv =====
// Front end: takes input transfers, classifies them, and queues them
module twcc_front (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        s_tvalid,
	output logic                        s_tready,
	input  logic [twcc_pkg::SEQ_W-1:0]  s_tdata,   // [31:0] cumulative ack
	input  logic [twcc_pkg::KIND_W-1:0] s_tuser,   // [1:0] kind
	output twcc_pkg::q_out_t            q_out,
	input  logic                        q_pop
);

	localparam int PTR_W = $clog2(twcc_pkg::QDEPTH);
	localparam int CNT_W = $clog2(twcc_pkg::QDEPTH + 1);

	twcc_pkg::ev_t      ev_dec;
	twcc_pkg::ev_item_t item_q [twcc_pkg::QDEPTH];
	logic [PTR_W-1:0]   wr_ptr_q;
	logic [PTR_W-1:0]   rd_ptr_q;
	logic [CNT_W-1:0]   count_q;
	logic               push;

	// kind decode
	always_comb begin
		case (s_tuser)
			twcc_pkg::KIND_START:   ev_dec = twcc_pkg::EV_START;
			twcc_pkg::KIND_ACK:     ev_dec = twcc_pkg::EV_ACK;
			twcc_pkg::KIND_TIMEOUT: ev_dec = twcc_pkg::EV_TIMEOUT;
			default:                ev_dec = twcc_pkg::EV_NONE;
		endcase
	end

	assign s_tready = (count_q != CNT_W'(twcc_pkg::QDEPTH));
	assign push     = s_tvalid & s_tready;

	// queue storage
	always_ff @(posedge clk) begin
		if (push) begin
			item_q[wr_ptr_q].ev  <= ev_dec;
			item_q[wr_ptr_q].ack <= s_tdata;
		end
	end

	// queue pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) wr_ptr_q <= wr_ptr_q + PTR_W'(1);
			if (q_pop) rd_ptr_q <= rd_ptr_q + PTR_W'(1);
			case ({push, q_pop})
				2'b10:   count_q <= count_q + CNT_W'(1);
				2'b01:   count_q <= count_q - CNT_W'(1);
				default: count_q <= count_q;
			endcase
		end
	end

	assign q_out.valid = (count_q != '0);
	assign q_out.item  = item_q[rd_ptr_q];

	`include "tcp_window_congestion_controller_core_assert.svh"

	`TWCC_ASSERT_ALWAYS(a_count_bound, count_q <= CNT_W'(twcc_pkg::QDEPTH), "queue overfilled")
	`TWCC_ASSERT_NEXT(a_pop_nonempty, q_pop, $past(count_q) != '0, "pop from empty queue")

endmodule

// ===== rtl/twcc_back.sv =====
// Back end: window state update per event and the registered result
module twcc_back (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [twcc_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [twcc_pkg::SEQ_W-1:0]     cfg_data,
	input  twcc_pkg::q_out_t               q_out,
	output logic                           q_pop,
	output logic                           m_tvalid,
	input  logic                           m_tready,
	output logic [twcc_pkg::OUT_W-1:0]     m_tdata
);

	localparam int SW = twcc_pkg::SEQ_W;
	localparam int CW = twcc_pkg::CWND_W;
	localparam int DW = twcc_pkg::DUP_W;

	// window state
	logic [SW-1:0] base_q, top_q, last_ack_q, last_seq_q, gm_q, ac_q;
	logic [CW-1:0] cwnd_q, ss_q, acks_q;
	logic [DW-1:0] dup_q;
	logic          mode_q, done_q;

	logic [SW-1:0] base_n, top_n, last_ack_n, gm_n, ac_n;
	logic [CW-1:0] cwnd_n, ss_n, acks_n;
	logic [DW-1:0] dup_n;
	logic          mode_n, done_n;

	// result fields
	logic [SW-1:0] r_first, r_last;
	logic [CW-1:0] r_count;
	logic          r_fin, r_ended;

	logic          m_tvalid_q;
	logic [twcc_pkg::OUT_W-1:0] m_tdata_q;

	// shared arithmetic
	logic [CW:0]   cwnd2;
	logic [CW-1:0] cwnd_dbl, cwnd_inc, acks_inc, cwnd_grow;
	logic [SW-1:0] adv, win_diff, ack;
	logic          do_end, grow, tmo, fire;
	twcc_pkg::ev_t ev;

	assign ev       = q_out.item.ev;
	assign ack      = q_out.item.ack;
	assign fire     = q_out.valid & (~m_tvalid_q | m_tready);
	assign q_pop    = fire;

	assign cwnd2    = {cwnd_q, 1'b0};
	assign cwnd_dbl = (cwnd2 > {1'b0, twcc_pkg::CWND_MAX}) ? twcc_pkg::CWND_MAX : cwnd2[CW-1:0];
	assign cwnd_inc = (cwnd_q < twcc_pkg::CWND_MAX) ? cwnd_q + CW'(1) : cwnd_q;
	assign acks_inc = acks_q + CW'(1);
	assign adv      = ack - last_ack_q;
	assign win_diff = last_seq_q - base_q;

	// next state for the event at the queue head
	always_comb begin
		base_n     = base_q;
		top_n      = top_q;
		last_ack_n = last_ack_q;
		gm_n       = gm_q;
		ac_n       = ac_q;
		cwnd_n     = cwnd_q;
		ss_n       = ss_q;
		acks_n     = acks_q;
		dup_n      = dup_q;
		mode_n     = mode_q;
		done_n     = done_q;
		r_first    = '0;
		r_last     = '0;
		r_count    = '0;
		r_fin      = 1'b0;
		r_ended    = 1'b0;
		do_end     = 1'b0;
		grow       = 1'b0;
		tmo        = 1'b0;
		cwnd_grow  = cwnd_q;
		if (!done_q) begin
			case (ev)
				twcc_pkg::EV_START: begin
					gm_n   = SW'(cwnd_q);
					ac_n   = '0;
					acks_n = '0;
					if (base_q <= last_seq_q) begin
						r_first = base_q;
						// window clipped at the last sequence
						if (win_diff < SW'(cwnd_q)) begin
							r_count = win_diff[CW-1:0] + CW'(1);
							r_last  = last_seq_q;
							r_fin   = 1'b1;
						end else begin
							r_count = cwnd_q;
							r_last  = base_q + SW'(cwnd_q) - SW'(1);
						end
						top_n = r_last;
					end
				end
				twcc_pkg::EV_ACK: begin
					if (ack == top_q) begin
						// full ack of the window top
						dup_n      = '0;
						last_ack_n = ack;
						if (ack == last_seq_q) begin
							done_n = 1'b1;
						end else begin
							do_end = 1'b1;
							grow   = 1'b1;
						end
					end else begin
						if (ack == last_ack_q) begin
							if (dup_q != {DW{1'b1}}) dup_n = dup_q + DW'(1);
						end else begin
							last_ack_n = ack;
							if (ack == last_seq_q) done_n = 1'b1;
							else if (!mode_q) gm_n = gm_q + adv;
							else ac_n = ac_q + adv;
						end
						if (!done_n) begin
							acks_n = acks_inc;
							if (acks_inc >= cwnd_q) begin
								do_end = 1'b1;
								grow   = mode_q ? (ac_n == SW'(cwnd_q)) : (gm_n == SW'(cwnd2));
							end
						end
					end
				end
				twcc_pkg::EV_TIMEOUT: begin
					ss_n   = cwnd_q >> 1;
					dup_n  = '0;
					do_end = 1'b1;
					tmo    = 1'b1;
				end
				default: begin
				end
			endcase
		end
		// round close: move base, grow window (or reset it on timeout), clear round accumulators
		if (do_end) begin
			r_ended = 1'b1;
			base_n  = last_ack_n + SW'(1);
			if (tmo) begin
				cwnd_n = CW'(1);
				mode_n = 1'b0;
			end else if (!mode_q) begin
				cwnd_grow = grow ? cwnd_dbl : cwnd_q;
				cwnd_n    = cwnd_grow;
				mode_n    = (cwnd_grow >= ss_q);
			end else begin
				cwnd_n = grow ? cwnd_inc : cwnd_q;
			end
			gm_n   = SW'(cwnd_n);
			ac_n   = '0;
			acks_n = '0;
		end
	end

	// state registers and configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q     <= '0;
			top_q      <= '1;
			last_ack_q <= '1;
			last_seq_q <= '0;
			gm_q       <= '0;
			ac_q       <= '0;
			cwnd_q     <= CW'(1);
			ss_q       <= twcc_pkg::SSTHRESH_RST;
			acks_q     <= '0;
			dup_q      <= '0;
			mode_q     <= 1'b0;
			done_q     <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_index)
				twcc_pkg::CFG_FIRST_SEQ: begin
					base_q     <= cfg_data;
					top_q      <= cfg_data - SW'(1);
					last_ack_q <= cfg_data - SW'(1);
				end
				twcc_pkg::CFG_LAST_SEQ: last_seq_q <= cfg_data;
				twcc_pkg::CFG_SSTHRESH: ss_q <= cfg_data[CW-1:0];
				default: begin
				end
			endcase
		end else if (fire) begin
			base_q     <= base_n;
			top_q      <= top_n;
			last_ack_q <= last_ack_n;
			gm_q       <= gm_n;
			ac_q       <= ac_n;
			cwnd_q     <= cwnd_n;
			ss_q       <= ss_n;
			acks_q     <= acks_n;
			dup_q      <= dup_n;
			mode_q     <= mode_n;
			done_q     <= done_n;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (fire) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			m_tdata_q <= {3'b000, dup_n, ss_n, cwnd_n, mode_n, done_n, r_ended, r_fin,
				r_count, r_last, r_first};
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

	`include "tcp_window_congestion_controller_core_assert.svh"

	`TWCC_ASSERT_ALWAYS(a_cwnd_range, cwnd_q != '0 && cwnd_q <= twcc_pkg::CWND_MAX, "cwnd out of range")
	`TWCC_ASSERT_ALWAYS(a_acks_below_cwnd, acks_q < cwnd_q, "round ack count reached cwnd")
	`TWCC_ASSERT_NEXT(a_done_sticky, done_q, done_q, "finished flag dropped")
	`TWCC_ASSERT_NEXT(a_result_after_fire, $rose(m_tvalid_q), $past(q_out.valid, 2), "result without event")

endmodule

// ===== rtl/tcp_window_congestion_controller_core.sv =====
// Top level of the round-based congestion window controller
// Takes one event per clock (start, ack, timeout) unless the queue is full, and
// returns one result per event. A two-entry queue sits between the decoding front
// end and the back end that updates the window state, so either side can stall
// alone. The back end resolves each event combinationally, including round close
// and window growth, so it sustains one event per cycle unless the output stalls.
// Input passes the queue register, then the output register. Configuration writes
// go straight to the state registers and must be made while no event is in flight.
module tcp_window_congestion_controller_core (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [twcc_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [twcc_pkg::SEQ_W-1:0]     cfg_data,
	input  logic                           s_tvalid,
	output logic                           s_tready,
	input  logic [twcc_pkg::SEQ_W-1:0]     s_tdata,   // [31:0] cumulative ack
	input  logic [twcc_pkg::KIND_W-1:0]    s_tuser,   // [1:0] kind
	output logic                           m_tvalid,
	input  logic                           m_tready,
	// [31:0] send_first, [63:32] send_last, [74:64] send_count,
	// [75] final_in_window, [76] round_ended, [77] finished, [78] mode,
	// [89:79] window_size, [100:90] threshold_now, [116:101] duplicate_acks, [119:117] zero
	output logic [twcc_pkg::OUT_W-1:0]     m_tdata
);

	twcc_pkg::q_out_t q_out;
	logic             q_pop;

	twcc_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.q_out    (q_out),
		.q_pop    (q_pop)
	);

	twcc_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.q_out     (q_out),
		.q_pop     (q_pop),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata)
	);

endmodule
